/* design/cgos_pkg.sv */
// Shared types and constants for the central gravity orbit step core.
// No dependencies; of the files in design/, only the top level imports this package.
package cgos_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [15:0]        time_step;
        logic               captured_in;
        logic               wrapped_in;
    } body_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               captured_out;
        logic               wrapped_out;
    } result_t;

    localparam int BODY_W = $bits(body_t);

    // register indexes of the config port
    localparam logic [1:0] CFG_GRAVITY = 2'd0;
    localparam logic [1:0] CFG_FIELD_W = 2'd1;
    localparam logic [1:0] CFG_FIELD_H = 2'd2;

    localparam logic [31:0] GRAVITY_RESET = 32'd65536;
    localparam logic [11:0] FIELD_W_RESET = 12'd640;
    localparam logic [11:0] FIELD_H_RESET = 12'd480;

    localparam logic [63:0] CAPTURE_RADIUS_SQ = 64'd1600;
    localparam logic [47:0] R2_MIN            = 48'd65536;

    // unit geometry
    localparam int SQRT_RW  = 64;   // radicand r2 << 16
    localparam int Q_NW     = 56;   // eg << 16
    localparam int Q_DW     = 48;   // r2
    localparam int Q_QBITS  = 40;
    localparam int N_NW     = 48;   // |p| << 16
    localparam int N_DW     = 32;   // r
    localparam int N_QBITS  = 18;   // |p|/r stays below 4

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] u;
        u = v;
        return v[31] ? (~u + 32'd1) : u;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // {wrapped, value}
    function automatic logic [32:0] wrap_axis(input logic signed [31:0] p,
                                              input logic [11:0] field);
        logic signed [33:0] pe;
        logic signed [33:0] half;
        logic signed [33:0] full;
        logic signed [33:0] res;
        logic               hit;
        pe   = 34'(p);
        half = $signed({7'd0, field, 15'd0});
        full = $signed({6'd0, field, 16'd0});
        res  = pe;
        hit  = 1'b0;
        if (pe > half) begin
            res = pe - full;
            hit = 1'b1;
        end else if (pe < -half) begin
            res = pe + full;
            hit = 1'b1;
        end
        return {hit, res[31:0]};
    endfunction

endpackage

/* design/cgos_sqrt.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Carries a sideband word alongside; no package dependencies.
module cgos_sqrt #(
    parameter int RW = 64,
    parameter int SW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  logic [RW-1:0]     radicand,
    input  logic [SW-1:0]     side_in,
    output logic              valid_out,
    output logic [RW/2-1:0]   root,
    output logic [SW-1:0]     side_out
);
    localparam int STEPS = RW / 2;
    localparam int REMW  = STEPS + 2;

    logic              valid_reg [STEPS];
    logic [REMW-1:0]   rem_reg   [STEPS];
    logic [STEPS-1:0]  root_reg  [STEPS];
    logic [RW-1:0]     rad_reg   [STEPS];
    logic [SW-1:0]     side_reg  [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic              src_valid;
        logic [REMW-1:0]   src_rem;
        logic [STEPS-1:0]  src_root;
        logic [RW-1:0]     src_rad;
        logic [SW-1:0]     src_side;
        logic [REMW-1:0]   rem_sh;
        logic [REMW-1:0]   trial;
        logic [REMW-1:0]   rem_next;
        logic [STEPS-1:0]  root_next;

        if (i == 0) begin : g_src_in
            assign src_valid = valid_in;
            assign src_rem   = '0;
            assign src_root  = '0;
            assign src_rad   = radicand;
            assign src_side  = side_in;
        end else begin : g_src_reg
            assign src_valid = valid_reg[i-1];
            assign src_rem   = rem_reg[i-1];
            assign src_root  = root_reg[i-1];
            assign src_rad   = rad_reg[i-1];
            assign src_side  = side_reg[i-1];
        end

        always_comb
        begin
            rem_sh = {src_rem[REMW-3:0], src_rad[RW-1:RW-2]};
            trial  = {src_root, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {src_root[STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {src_root[STEPS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else
                valid_reg[i] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= rem_next;
            root_reg[i] <= root_next;
            rad_reg[i]  <= {src_rad[RW-3:0], 2'b00};
            side_reg[i] <= src_side;
        end
    end

    assign valid_out = valid_reg[STEPS-1];
    assign root      = root_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];

endmodule

/* design/cgos_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Requires num < den * 2**QW; carries a sideband word; no package dependencies.
module cgos_div #(
    parameter int NW = 56,
    parameter int DW = 48,
    parameter int QW = 40,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid_in,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          valid_out,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] side_out
);
    logic          valid_reg [QW];
    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] low_reg   [QW];   // numerator bits out, quotient bits in
    logic [DW-1:0] den_reg   [QW];
    logic [SW-1:0] side_reg  [QW];

    for (genvar i = 0; i < QW; i++) begin : g_step
        logic          src_valid;
        logic [DW-1:0] src_rem;
        logic [QW-1:0] src_low;
        logic [DW-1:0] src_den;
        logic [SW-1:0] src_side;
        logic [DW:0]   rem_sh;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;
        logic          qbit;

        if (i == 0) begin : g_src_in
            assign src_valid = valid_in;
            assign src_rem   = DW'(num >> QW);
            assign src_low   = num[QW-1:0];
            assign src_den   = den;
            assign src_side  = side_in;
        end else begin : g_src_reg
            assign src_valid = valid_reg[i-1];
            assign src_rem   = rem_reg[i-1];
            assign src_low   = low_reg[i-1];
            assign src_den   = den_reg[i-1];
            assign src_side  = side_reg[i-1];
        end

        always_comb
        begin
            rem_sh = {src_rem, src_low[QW-1]};
            diff   = rem_sh - {1'b0, src_den};
            qbit   = (rem_sh >= {1'b0, src_den});
            rem_next = qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else
                valid_reg[i] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= rem_next;
            low_reg[i]  <= {src_low[QW-2:0], qbit};
            den_reg[i]  <= src_den;
            side_reg[i] <= src_side;
        end
    end

    assign valid_out = valid_reg[QW-1];
    assign quot      = low_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

/* design/central_gravity_orbit_step_core.sv */
// Top level of the central gravity orbit step core (symplectic Euler, Q16.16).
// Uses cgos_pkg, cgos_sqrt and cgos_div.
//
// Usage:
//   Input channel: a body word on body is taken at each rising edge with
//   start high and busy low. busy is always low: the core is a fixed
//   pipeline and takes one word every cycle.
//   Output channel: done is high for exactly one cycle with the result word
//   on result. Words leave in the order they came in, one result per body.
//   The receiver cannot stall the core and none is needed: nothing inside
//   waits on the output.
//   Latency is set by the root unit (32 stages, one root bit each) followed
//   by the |p|/r dividers (18 stages); the r2 divider (40 stages) runs in
//   parallel and its quotient waits in a 10-deep delay line.
//   Config port: cfg_we writes cfg_data into register cfg_index at the edge
//   (0 gravity strength, 1 field width, 2 field height). Write only while
//   no body is in flight.
//   Reset (rst_n low, asynchronous) clears all in-flight words and returns
//   the registers to gravity 1.0, field 640 x 480. No clearing pass.
module central_gravity_orbit_step_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cgos_pkg::body_t   body,
    output logic              done,
    output cgos_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import cgos_pkg::*;

    localparam int QDLY    = SQRT_RW / 2 + N_QBITS - Q_QBITS;
    localparam int OUT_LAT = 1 + SQRT_RW / 2 + N_QBITS + 6;

    // ---------------- config registers ----------------
    logic [31:0] gravity_reg;
    logic [11:0] field_w_reg;
    logic [11:0] field_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= GRAVITY_RESET;
            field_w_reg <= FIELD_W_RESET;
            field_h_reg <= FIELD_H_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRAVITY: gravity_reg <= cfg_data;
                CFG_FIELD_W: field_w_reg <= cfg_data[11:0];
                CFG_FIELD_H: field_h_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- stage A: squares, gravity * step ----------------
    logic        a_valid_reg;
    body_t       a_item_reg;
    logic [63:0] a_sqx_reg, a_sqy_reg;
    logic [47:0] a_egp_reg;
    logic [31:0] a_ax, a_ay;

    assign a_ax = mag32(body.pos_x);
    assign a_ay = mag32(body.pos_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        a_item_reg <= body;
        a_sqx_reg  <= 64'(a_ax) * 64'(a_ax);
        a_sqy_reg  <= 64'(a_ay) * 64'(a_ay);
        a_egp_reg  <= 48'(gravity_reg) * 48'(body.time_step);
    end

    // ---------------- stage B: r2 with floor of one, eg ----------------
    logic        b_valid_reg;
    body_t       b_item_reg;
    logic [47:0] b_r2_reg, b_r2_next;
    logic [39:0] b_eg_reg;
    logic [63:0] b_sum;

    always_comb
    begin
        b_sum     = a_sqx_reg + a_sqy_reg;
        b_r2_next = (b_sum[63:16] < R2_MIN) ? R2_MIN : b_sum[63:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_item_reg <= a_item_reg;
        b_r2_reg   <= b_r2_next;
        b_eg_reg   <= a_egp_reg[47:8];
    end

    // ---------------- root and q = (eg << 16) / r2 ----------------
    logic                   s_valid;
    logic [SQRT_RW/2-1:0]   s_root;
    logic [BODY_W-1:0]      s_side;
    body_t                  s_item;
    logic                   q_valid;
    logic [Q_QBITS-1:0]     q_quot;

    cgos_sqrt #(.RW(SQRT_RW), .SW(BODY_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (b_valid_reg),
        .radicand  ({b_r2_reg, 16'd0}),
        .side_in   (b_item_reg),
        .valid_out (s_valid),
        .root      (s_root),
        .side_out  (s_side)
    );

    assign s_item = body_t'(s_side);

    cgos_div #(.NW(Q_NW), .DW(Q_DW), .QW(Q_QBITS), .SW(1)) u_div_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (b_valid_reg),
        .num       ({b_eg_reg, 16'd0}),
        .den       (b_r2_reg),
        .side_in   (1'b0),
        .valid_out (q_valid),
        .quot      (q_quot),
        .side_out  ()
    );

    logic [Q_QBITS-1:0] q_dly_reg [QDLY];

    always_ff @(posedge clk)
    begin
        q_dly_reg[0] <= q_quot;
        for (int i = 1; i < QDLY; i++)
            q_dly_reg[i] <= q_dly_reg[i-1];
    end

    // ---------------- n = (|p| << 16) / r per axis ----------------
    logic               nx_valid, ny_valid;
    logic [N_QBITS-1:0] nx_quot, ny_quot;
    logic [BODY_W-1:0]  n_side;
    body_t              n_item;

    cgos_div #(.NW(N_NW), .DW(N_DW), .QW(N_QBITS), .SW(BODY_W)) u_div_nx (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s_valid),
        .num       ({mag32(s_item.pos_x), 16'd0}),
        .den       (s_root),
        .side_in   (s_side),
        .valid_out (nx_valid),
        .quot      (nx_quot),
        .side_out  (n_side)
    );

    cgos_div #(.NW(N_NW), .DW(N_DW), .QW(N_QBITS), .SW(1)) u_div_ny (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s_valid),
        .num       ({mag32(s_item.pos_y), 16'd0}),
        .den       (s_root),
        .side_in   (1'b0),
        .valid_out (ny_valid),
        .quot      (ny_quot),
        .side_out  ()
    );

    assign n_item = body_t'(n_side);

    // ---------------- stage M: q * n ----------------
    logic        m_valid_reg;
    body_t       m_item_reg;
    logic [57:0] m_px_reg, m_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= nx_valid;
    end

    always_ff @(posedge clk)
    begin
        m_item_reg <= n_item;
        m_px_reg   <= 58'(q_dly_reg[QDLY-1]) * 58'(nx_quot);
        m_py_reg   <= 58'(q_dly_reg[QDLY-1]) * 58'(ny_quot);
    end

    // ---------------- stage V: v' = sat(v - d) ----------------
    logic               v_valid_reg;
    body_t              v_item_reg;
    logic signed [31:0] v_vx_reg, v_vx_next;
    logic signed [31:0] v_vy_reg, v_vy_next;
    logic signed [63:0] v_dx, v_dy;

    always_comb
    begin
        v_dx = $signed(64'(m_px_reg[57:16]));
        v_dy = $signed(64'(m_py_reg[57:16]));
        if (m_item_reg.pos_x[31])
            v_dx = -v_dx;
        if (m_item_reg.pos_y[31])
            v_dy = -v_dy;
        v_vx_next = sat32(64'(m_item_reg.vel_x) - v_dx);
        v_vy_next = sat32(64'(m_item_reg.vel_y) - v_dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_valid_reg <= 1'b0;
        else
            v_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        v_item_reg <= m_item_reg;
        v_vx_reg   <= v_vx_next;
        v_vy_reg   <= v_vy_next;
    end

    // ---------------- stage T: |v'| * step ----------------
    logic               t_valid_reg;
    body_t              t_item_reg;
    logic signed [31:0] t_vx_reg, t_vy_reg;
    logic [47:0]        t_mx_reg, t_my_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_valid_reg <= 1'b0;
        else
            t_valid_reg <= v_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        t_item_reg <= v_item_reg;
        t_vx_reg   <= v_vx_reg;
        t_vy_reg   <= v_vy_reg;
        t_mx_reg   <= 48'(mag32(v_vx_reg)) * 48'(v_item_reg.time_step);
        t_my_reg   <= 48'(mag32(v_vy_reg)) * 48'(v_item_reg.time_step);
    end

    // ---------------- stage P: p' = sat(p + m) ----------------
    logic               p_valid_reg;
    body_t              p_item_reg;
    logic signed [31:0] p_vx_reg, p_vy_reg;
    logic signed [31:0] p_x_reg, p_x_next;
    logic signed [31:0] p_y_reg, p_y_next;
    logic signed [63:0] p_mx, p_my;

    always_comb
    begin
        p_mx = $signed(64'(t_mx_reg[47:8]));
        p_my = $signed(64'(t_my_reg[47:8]));
        if (t_vx_reg[31])
            p_mx = -p_mx;
        if (t_vy_reg[31])
            p_my = -p_my;
        p_x_next = sat32(64'(t_item_reg.pos_x) + p_mx);
        p_y_next = sat32(64'(t_item_reg.pos_y) + p_my);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else
            p_valid_reg <= t_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        p_item_reg <= t_item_reg;
        p_vx_reg   <= t_vx_reg;
        p_vy_reg   <= t_vy_reg;
        p_x_reg    <= p_x_next;
        p_y_reg    <= p_y_next;
    end

    // ---------------- stage C: capture squares ----------------
    logic               c_valid_reg;
    body_t              c_item_reg;
    logic signed [31:0] c_vx_reg, c_vy_reg, c_x_reg, c_y_reg;
    logic [63:0]        c_sqx_reg, c_sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        c_item_reg <= p_item_reg;
        c_vx_reg   <= p_vx_reg;
        c_vy_reg   <= p_vy_reg;
        c_x_reg    <= p_x_reg;
        c_y_reg    <= p_y_reg;
        c_sqx_reg  <= 64'(mag32(p_x_reg)) * 64'(mag32(p_x_reg));
        c_sqy_reg  <= 64'(mag32(p_y_reg)) * 64'(mag32(p_y_reg));
    end

    // ---------------- output: capture test, wrap, bypass ----------------
    logic    done_reg;
    result_t result_reg, result_next;
    logic    capt;
    logic [32:0] wrx, wry;

    always_comb
    begin
        capt = (c_sqx_reg + c_sqy_reg) < (CAPTURE_RADIUS_SQ << 32);
        wrx  = wrap_axis(c_x_reg, field_w_reg);
        wry  = wrap_axis(c_y_reg, field_h_reg);
        if (c_item_reg.captured_in)
        begin
            result_next.new_pos_x    = c_item_reg.pos_x;
            result_next.new_pos_y    = c_item_reg.pos_y;
            result_next.new_vel_x    = c_item_reg.vel_x;
            result_next.new_vel_y    = c_item_reg.vel_y;
            result_next.captured_out = 1'b1;
            result_next.wrapped_out  = c_item_reg.wrapped_in;
        end
        else if (capt)
        begin
            result_next.new_pos_x    = c_x_reg;
            result_next.new_pos_y    = c_y_reg;
            result_next.new_vel_x    = c_vx_reg;
            result_next.new_vel_y    = c_vy_reg;
            result_next.captured_out = 1'b1;
            result_next.wrapped_out  = c_item_reg.wrapped_in;
        end
        else
        begin
            result_next.new_pos_x    = wrx[31:0];
            result_next.new_pos_y    = wry[31:0];
            result_next.new_vel_x    = c_vx_reg;
            result_next.new_vel_y    = c_vy_reg;
            result_next.captured_out = 1'b0;
            result_next.wrapped_out  = c_item_reg.wrapped_in | wrx[32] | wry[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- checks ----------------
    a_ndiv_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        nx_valid == ny_valid)
        else $error("n divider lanes out of step");

    a_q_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        nx_valid == $past(q_valid, QDLY))
        else $error("q delay line misaligned with n dividers");

    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(a_valid_reg, OUT_LAT))
        else $error("result word does not match pipeline latency");

endmodule
